>>> rtl/core/numeric_type_converter_defines.svh
// Assertion macros used by the converter RTL.
`ifndef NUMERIC_TYPE_CONVERTER_DEFINES_SVH
`define NUMERIC_TYPE_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NTC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("converter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("converter assertion failed");

`endif

>>> rtl/core/ntc_pkg.sv
// Shared types, type codes and register constants of the numeric type converter.
package ntc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int DATA_WIDTH          = 64;
   localparam int CSR_INDEX_WIDTH     = 3;

   // Element type codes.
   localparam logic [2:0] TYPE_BYTE    = 3'd0;
   localparam logic [2:0] TYPE_LOGICAL = 3'd1;
   localparam logic [2:0] TYPE_WORD    = 3'd2;
   localparam logic [2:0] TYPE_INT     = 3'd3;
   localparam logic [2:0] TYPE_REAL    = 3'd4;
   localparam logic [2:0] TYPE_DOUBLE  = 3'd5;
   localparam logic [2:0] TYPE_CHAR    = 3'd6;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IN_TYPE    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_TYPE   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAD_BYTE   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAD_WORD   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAD_INT    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAD_REAL   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAD_DOUBLE = 3'd6;

   // Register reset values.
   localparam logic [7:0]  BAD_BYTE_RESET   = 8'h81;
   localparam logic [15:0] BAD_WORD_RESET   = 16'h8001;
   localparam logic [31:0] BAD_INT_RESET    = 32'h8000_0001;
   localparam logic [31:0] BAD_REAL_RESET   = 32'hFF7F_FFFF;
   localparam logic [63:0] BAD_DOUBLE_RESET = 64'hFFEF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  in_type;
      logic [2:0]  out_type;
      logic [7:0]  bad_byte;
      logic [15:0] bad_word;
      logic [31:0] bad_int;
      logic [31:0] bad_real;
      logic [63:0] bad_double;
   } ntc_cfg_type;

endpackage

>>> rtl/core/ntc_csr.sv
// Configuration register file of the numeric type converter.
module ntc_csr
   import ntc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wdata,
   output ntc_cfg_type                cfg
);

   ntc_cfg_type cfg_ff;
   ntc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IN_TYPE:    cfg_in.in_type    = csr_wdata[2:0];
            CSR_OUT_TYPE:   cfg_in.out_type   = csr_wdata[2:0];
            CSR_BAD_BYTE:   cfg_in.bad_byte   = csr_wdata[7:0];
            CSR_BAD_WORD:   cfg_in.bad_word   = csr_wdata[15:0];
            CSR_BAD_INT:    cfg_in.bad_int    = csr_wdata[31:0];
            CSR_BAD_REAL:   cfg_in.bad_real   = csr_wdata[31:0];
            CSR_BAD_DOUBLE: cfg_in.bad_double = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_type    <= TYPE_BYTE;
         cfg_ff.out_type   <= TYPE_BYTE;
         cfg_ff.bad_byte   <= BAD_BYTE_RESET;
         cfg_ff.bad_word   <= BAD_WORD_RESET;
         cfg_ff.bad_int    <= BAD_INT_RESET;
         cfg_ff.bad_real   <= BAD_REAL_RESET;
         cfg_ff.bad_double <= BAD_DOUBLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/ntc_convert.sv
// Combinational element conversion between the integer, logical and floating types.
module ntc_convert
   import ntc_pkg::*;
(
   input  ntc_cfg_type           cfg,
   input  logic [DATA_WIDTH-1:0] in_bits,
   output logic [DATA_WIDTH-1:0] out_bits,
   output logic                  range_error,
   output logic                  refused
);

   typedef struct packed {
      logic               ovf;
      logic signed [34:0] value;
   } round_type;

   // Exact widening of a single to a double; NaNs come out quiet.
   function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
      logic [4:0]  p;
      logic [23:0] norm;
      logic [63:0] r;
      p = '0;
      for (int i = 0; i < 23; i++) begin
         if (f[i]) p = 5'(i);
      end
      norm = 24'(f[22:0]) << (5'd23 - p);
      if (f[30:23] == 8'hFF) begin
         r = (f[22:0] == '0) ? {f[31], 11'h7FF, 52'b0}
                             : {f[31], 11'h7FF, 1'b1, f[21:0], 29'b0};
      end else if (f[30:23] != '0) begin
         r = {f[31], {3'b0, f[30:23]} + 11'd896, f[22:0], 29'b0};
      end else if (f[22:0] == '0) begin
         r = {f[31], 63'b0};
      end else begin
         r = {f[31], 11'd874 + {6'b0, p}, norm[22:0], 29'b0};
      end
      return r;
   endfunction

   // Exact conversion of a 32-bit two's complement value to a double.
   function automatic logic [63:0] int_to_f64(input logic [31:0] v);
      logic [31:0] mag;
      logic [31:0] n;
      logic [4:0]  p;
      mag = v[31] ? (~v + 32'd1) : v;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) p = 5'(i);
      end
      n = mag << (5'd31 - p);
      return (mag == '0) ? 64'b0 : {v[31], 11'd1023 + {6'b0, p}, n[30:0], 21'b0};
   endfunction

   // Round-to-nearest-even conversion of a 32-bit integer to a single.
   function automatic logic [31:0] int_to_f32(input logic [31:0] v);
      logic [31:0] mag;
      logic [31:0] n;
      logic [4:0]  p;
      logic        inc;
      mag = v[31] ? (~v + 32'd1) : v;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) p = 5'(i);
      end
      n = mag << (5'd31 - p);
      inc = n[7] & ((|n[6:0]) | n[8]);
      return (mag == '0) ? 32'b0
                         : {v[31], {8'd127 + {3'b0, p}, n[30:8]} + {30'b0, inc}};
   endfunction

   // Round-to-nearest-even narrowing of a finite double within single range.
   function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
      logic [10:0]  e;
      logic [10:0]  ew;
      logic [10:0]  shw;
      logic [52:0]  w;
      logic [5:0]   sh;
      logic [106:0] z;
      logic         normal;
      logic         inc;
      logic [30:0]  base;
      e = d[62:52];
      w = {1'b1, d[51:0]};
      normal = (e >= 11'd897);
      shw = 11'd926 - e;
      ew = e - 11'd896;
      if (normal) begin
         sh = 6'd29;
      end else if (e < 11'd872) begin
         sh = 6'd54;
      end else begin
         sh = shw[5:0];
      end
      z = {w, 54'b0} >> sh;
      inc = z[53] & ((|z[52:0]) | z[54]);
      base = normal ? {ew[7:0], z[76:54]} : {8'b0, z[76:54]};
      return (e == '0) ? {d[63], 31'b0} : {d[63], base + {30'b0, inc}};
   endfunction

   // a <= b for doubles that are not NaN.
   function automatic logic le_f64(input logic [63:0] a, input logic [63:0] b);
      logic r;
      if (a[62:0] == '0 && b[62:0] == '0) begin
         r = 1'b1;
      end else if (a[63] != b[63]) begin
         r = a[63];
      end else if (!a[63]) begin
         r = (a[62:0] <= b[62:0]);
      end else begin
         r = (a[62:0] >= b[62:0]);
      end
      return r;
   endfunction

   // floor(d + 0.5) as the double sum rounds it. The rounded sum keeps the exact floor for
   // every finite input within 32-bit range but one: the double just below one half rounds up to 1.
   function automatic round_type round_half_up(input logic [63:0] d);
      logic [10:0] e;
      logic [10:0] shw;
      logic [52:0] w;
      logic [86:0] x;
      logic [33:0] ip;
      logic        h;
      logic        st;
      logic [34:0] mag;
      round_type   r;
      e = d[62:52];
      w = {e != '0, d[51:0]};
      shw = e - 11'd1022;
      x = {34'b0, w} << shw[5:0];
      if (e < 11'd1022) begin
         ip = '0;
         h  = 1'b0;
         st = |w;
      end else begin
         ip = x[86:53];
         h  = x[52];
         st = |x[51:0];
      end
      mag = {1'b0, ip} + {34'b0, d[63] ? (h & st) : h};
      r.ovf = (e == 11'h7FF) || (e >= 11'd1056) ||
              (!d[63] && mag >= 35'h0_8000_0000) || (d[63] && mag > 35'h0_8000_0001);
      r.value = d[63] ? (~mag + 35'd1) : mag;
      if (d == 64'h3FDF_FFFF_FFFF_FFFF) begin
         r.ovf   = 1'b0;
         r.value = 35'sd1;
      end
      return r;
   endfunction

   function automatic logic [63:0] bad_of(input logic [2:0] t, input ntc_cfg_type c);
      logic [63:0] r;
      case (t)
         TYPE_BYTE:   r = {56'b0, c.bad_byte};
         TYPE_WORD:   r = {48'b0, c.bad_word};
         TYPE_INT:    r = {32'b0, c.bad_int};
         TYPE_REAL:   r = {32'b0, c.bad_real};
         TYPE_DOUBLE: r = c.bad_double;
         default:     r = 64'b0;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] type_bits(input logic [2:0] t);
      logic [6:0] r;
      case (t) inside
         TYPE_BYTE, TYPE_LOGICAL: r = 7'd8;
         TYPE_WORD:               r = 7'd16;
         TYPE_INT, TYPE_REAL:     r = 7'd32;
         default:                 r = 7'd64;
      endcase
      return r;
   endfunction

   logic [63:0]        src_val;
   logic signed [34:0] src_int;
   logic [63:0]        src_dbl;
   logic               is_float;
   logic [63:0]        bad_in;
   logic [63:0]        bad_out;
   logic               src_is_bad;
   logic               nonzero;
   round_type          rnd;
   logic signed [34:0] int_val;
   logic signed [34:0] bad_sext;
   logic signed [34:0] max_val;
   logic               narrow;
   logic               int_range;
   logic [63:0]        int_out;
   logic               fbad_nan;
   logic               dbl_range;

   always_comb begin
      case (cfg.in_type) inside
         TYPE_BYTE, TYPE_LOGICAL: begin
            src_val = {56'b0, in_bits[7:0]};
            src_int = {{27{in_bits[7]}}, in_bits[7:0]};
         end
         TYPE_WORD: begin
            src_val = {48'b0, in_bits[15:0]};
            src_int = {{19{in_bits[15]}}, in_bits[15:0]};
         end
         TYPE_INT: begin
            src_val = {32'b0, in_bits[31:0]};
            src_int = {{3{in_bits[31]}}, in_bits[31:0]};
         end
         TYPE_REAL: begin
            src_val = {32'b0, in_bits[31:0]};
            src_int = '0;
         end
         default: begin
            src_val = in_bits;
            src_int = '0;
         end
      endcase

      is_float   = (cfg.in_type == TYPE_REAL) || (cfg.in_type == TYPE_DOUBLE);
      src_dbl    = (cfg.in_type == TYPE_REAL) ? f32_to_f64(in_bits[31:0]) : in_bits;
      bad_in     = bad_of(cfg.in_type, cfg);
      bad_out    = bad_of(cfg.out_type, cfg);
      src_is_bad = (cfg.in_type != TYPE_LOGICAL) && (src_val == bad_in);

      // A NaN counts as nonzero, and either signed zero as zero.
      case (cfg.in_type)
         TYPE_REAL:   nonzero = |in_bits[30:0];
         TYPE_DOUBLE: nonzero = |in_bits[62:0];
         default:     nonzero = (src_int != '0);
      endcase

      rnd     = round_half_up(src_dbl);
      int_val = is_float ? rnd.value : src_int;

      case (cfg.out_type)
         TYPE_BYTE: begin
            bad_sext = {{27{cfg.bad_byte[7]}}, cfg.bad_byte};
            max_val  = 35'sd127;
            int_out  = {56'b0, int_val[7:0]};
         end
         TYPE_WORD: begin
            bad_sext = {{19{cfg.bad_word[15]}}, cfg.bad_word};
            max_val  = 35'sd32767;
            int_out  = {48'b0, int_val[15:0]};
         end
         default: begin
            bad_sext = {{3{cfg.bad_int[31]}}, cfg.bad_int};
            max_val  = 35'sd2147483647;
            int_out  = {32'b0, int_val[31:0]};
         end
      endcase

      // Only narrowing integer moves and float sources get a range check.
      narrow = is_float || ((cfg.in_type != TYPE_LOGICAL) &&
                            (type_bits(cfg.in_type) > type_bits(cfg.out_type)));
      int_range = (is_float && rnd.ovf) ||
                  (narrow && ((int_val <= bad_sext) || (int_val > max_val)));

      // Double to real: NaN, beyond the largest single, or at or below the bad value.
      fbad_nan  = (cfg.bad_real[30:23] == 8'hFF) && (cfg.bad_real[22:0] != '0);
      dbl_range = (src_dbl[62:0] > 63'h47EF_FFFF_E000_0000) ||
                  (!fbad_nan && le_f64(src_dbl, f32_to_f64(cfg.bad_real)));

      out_bits    = '0;
      range_error = 1'b0;
      refused     = 1'b0;
      if (cfg.in_type == TYPE_CHAR && cfg.out_type == TYPE_CHAR) begin
         out_bits = in_bits;
      end else if (cfg.in_type >= TYPE_CHAR || cfg.out_type >= TYPE_CHAR) begin
         refused = 1'b1;
      end else if (cfg.in_type == cfg.out_type) begin
         out_bits = src_val;
      end else if (src_is_bad) begin
         out_bits = (cfg.out_type == TYPE_LOGICAL) ? 64'b0 : bad_out;
      end else begin
         case (cfg.out_type) inside
            TYPE_LOGICAL: begin
               out_bits = {63'b0, nonzero};
            end
            TYPE_BYTE, TYPE_WORD, TYPE_INT: begin
               range_error = int_range;
               out_bits    = int_range ? bad_out : int_out;
            end
            TYPE_REAL: begin
               if (is_float) begin
                  range_error = dbl_range;
                  out_bits    = dbl_range ? {32'b0, cfg.bad_real}
                                          : {32'b0, f64_to_f32(src_dbl)};
               end else begin
                  out_bits = {32'b0, int_to_f32(src_int[31:0])};
               end
            end
            default: begin
               out_bits = is_float ? src_dbl : int_to_f64(src_int[31:0]);
            end
         endcase
      end
   end

endmodule

>>> rtl/core/numeric_type_converter.sv
// Numeric type converter: one accepted beat in, one converted beat out.
// The request register holds an accepted beat; its converted result is then loaded
// into the response register, which drives the response channel.
// Throughput is one beat per clock while rsp_stall is low; the conversion is one pass
// of logic between the request register and the response register.
// Synchronous active-high reset empties both registers, clears the error tally and
// loads the type and bad-value registers with their defaults.
`include "numeric_type_converter_defines.svh"

module numeric_type_converter
   import ntc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [DATA_WIDTH-1:0]      req_in_bits,
   input  logic                       req_last_element,
   // Response channel.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DATA_WIDTH-1:0]      rsp_out_bits,
   output logic                       rsp_range_error,
   output logic                       rsp_refused,
   output logic [31:0]                rsp_error_count,
   output logic                       rsp_last_result,
   // Configuration write port.
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wdata
);

   ntc_cfg_type cfg;

   ntc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The request register holds one accepted beat until the response register
   // can take its converted result.
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [DATA_WIDTH-1:0] s1_bits_ff;
   logic                  s1_last_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_out_bits_ff;
   logic                  rsp_range_error_ff;
   logic                  rsp_refused_ff;
   logic [31:0]           rsp_error_count_ff;
   logic                  rsp_last_result_ff;

   logic [COUNT_WIDTH-1:0] tally_ff;
   logic [COUNT_WIDTH-1:0] tally_in;
   logic [COUNT_WIDTH-1:0] count_now;
   logic [63:0]            count_ext;

   logic [DATA_WIDTH-1:0] conv_bits;
   logic                  conv_range_error;
   logic                  conv_refused;

   logic advance;
   logic move;
   logic req_accept;

   ntc_convert u_convert (
      .cfg         (cfg),
      .in_bits     (s1_bits_ff),
      .out_bits    (conv_bits),
      .range_error (conv_range_error),
      .refused     (conv_refused)
   );

   // The response register is free when empty or when its beat leaves now.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign move       = advance && s1_valid_ff;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = (s1_valid_ff && !advance) ? 1'b1 : req_valid;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   // The tally saturates, counts this beat's error, and restarts after the
   // final element of an array so the last beat carries the array's total.
   assign count_now = (conv_range_error && (tally_ff != '1)) ? tally_ff + COUNT_WIDTH'(1)
                                                             : tally_ff;
   assign count_ext = 64'(count_now);
   assign tally_in  = move ? (s1_last_ff ? '0 : count_now) : tally_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tally_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tally_ff     <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_bits_ff <= req_in_bits;
         s1_last_ff <= req_last_element;
      end
      if (move) begin
         rsp_out_bits_ff    <= conv_bits;
         rsp_range_error_ff <= conv_range_error;
         rsp_refused_ff     <= conv_refused;
         rsp_error_count_ff <= count_ext[31:0];
         rsp_last_result_ff <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_bits    = rsp_out_bits_ff;
   assign rsp_range_error = rsp_range_error_ff;
   assign rsp_refused     = rsp_refused_ff;
   assign rsp_error_count = rsp_error_count_ff;
   assign rsp_last_result = rsp_last_result_ff;

   // A refused pair never produces data or a range error.
   `NTC_ASSERT_SAME(a_refused_clean, clock, reset, rsp_valid_ff && rsp_refused_ff, !rsp_range_error_ff && (rsp_out_bits_ff == '0))
   // The tally restarts after the last element of an array.
   `NTC_ASSERT_NEXT(a_tally_clear, clock, reset, move && s1_last_ff, tally_ff == '0)
   // Without a beat moving into the response register, the tally holds.
   `NTC_ASSERT_NEXT(a_tally_hold, clock, reset, !move, $stable(tally_ff))
   // A range error below saturation adds exactly one.
   `NTC_ASSERT_NEXT(a_tally_step, clock, reset, move && !s1_last_ff && conv_range_error && (tally_ff != '1), tally_ff == $past(tally_ff) + COUNT_WIDTH'(1))

endmodule
